// ===== src/wsm_pkg.sv =====
// Shared types and constants of the window standard deviation monitor.
package wsm_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FS_W     = 16;
  localparam int unsigned IND_W    = 16;

  // Number of quotient bits produced by the divider (indicator below 1.0).
  localparam int unsigned QBITS = 15;

  // Indicator value for 1.0 in Q1.15, used when the result saturates.
  localparam logic [IND_W-1:0] ONE_Q15 = 16'h8000;

  // Reset value of the full-scale deviation register.
  localparam logic [FS_W-1:0] FS_RESET = 16'd100;

  // Controller states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_SQNEW    = 11'b000_0000_0010,
    ST_SQOLD    = 11'b000_0000_0100,
    ST_UPDATE   = 11'b000_0000_1000,
    ST_MULINIT  = 11'b000_0001_0000,
    ST_MUL      = 11'b000_0010_0000,
    ST_SQRTINIT = 11'b000_0100_0000,
    ST_SQRT     = 11'b000_1000_0000,
    ST_DIVCHK   = 11'b001_0000_0000,
    ST_DIV      = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } wsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic sq_new;
    logic sq_old;
    logic update;
    logic mul_init;
    logic mul_step;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic finish;
  } wsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clamp;
  } wsm_status_t;

endpackage

// ===== src/wsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wsm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/wsm_datapath.sv =====
// Datapath: sample window, running sums, iterative multiply, square root and divide.
module wsm_datapath #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wsm_pkg::wsm_cmd_t             cmd,
  output wsm_pkg::wsm_status_t          status,
  input  logic                          cfg_wr_en,
  input  logic [wsm_pkg::FS_W-1:0]      cfg_wr_data,
  input  logic [wsm_pkg::SAMPLE_W-1:0]  sample_mv,
  output logic [wsm_pkg::IND_W-1:0]     indicator_q15
);

  import wsm_pkg::*;

  localparam int unsigned AW    = $clog2(WINDOW);
  localparam int unsigned CW    = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned SQ_W  = 2 * SAMPLE_W;
  localparam int unsigned Q_W   = SQ_W + $clog2(WINDOW);
  localparam int unsigned D_W   = 2 * SUM_W;
  localparam int unsigned RM_W  = SUM_W + 1;

  // Configuration and window bookkeeping.
  logic [FS_W-1:0]     fs_dev;
  logic [AW-1:0]       wpos;
  logic [CW-1:0]       fill;
  logic [SAMPLE_W-1:0] first_val;

  // Transaction registers.
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] old_r;
  logic                first_r;
  logic [SQ_W-1:0]     sq_new_r;
  logic [SQ_W-1:0]     sq_old_r;
  logic [SUM_W-1:0]    sum;
  logic [Q_W-1:0]      sumsq;

  // Iterative units.
  logic [D_W-1:0]      acc;
  logic [D_W-1:0]      mcand;
  logic [SUM_W-1:0]    mplier;
  logic [D_W-1:0]      dsh;
  logic [RM_W-1:0]     sq_rem;
  logic [SUM_W-1:0]    root;
  logic [SUM_W-1:0]    den;
  logic [RM_W-1:0]     dv_rem;
  logic [QBITS-1:0]    quot;
  logic                clamp_r;

  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] old_val;
  logic [SQ_W-1:0]     mul_out;
  logic [SAMPLE_W-1:0] mul_in;
  logic [FS_W-1:0]     fs_eff;
  logic [RM_W+1:0]     sq_shift;
  logic [RM_W+1:0]     sq_trial;
  logic [RM_W-1:0]     dv_shift;

  wsm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (wpos),
    .wr_data (sample_r),
    .rd_en   (cmd.accept),
    .rd_addr (wpos),
    .rd_data (rd_data)
  );

  // Entries not yet written are read as the first sample.
  assign old_val = (CW'(wpos) < fill) ? rd_data : first_val;

  // One shared 16x16 squarer.
  assign mul_in  = cmd.sq_old ? old_r : sample_r;
  assign mul_out = SQ_W'(mul_in) * SQ_W'(mul_in);

  // A full-scale setting of zero acts as one.
  assign fs_eff = (fs_dev == '0) ? FS_W'(1) : fs_dev;

  // Square root digit step and divider step.
  assign sq_shift = {sq_rem, dsh[D_W-1 -: 2]};
  assign sq_trial = (RM_W + 2)'({root, 2'b01});
  assign dv_shift = {dv_rem[RM_W-2:0], 1'b0};

  assign status.clamp = (root >= den);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_dev <= FS_RESET;
    end else if (cfg_wr_en) begin
      fs_dev <= cfg_wr_data;
    end
  end

  // Write position and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
      fill <= '0;
    end else if (cmd.update) begin
      wpos <= (wpos == AW'(WINDOW - 1)) ? '0 : wpos + 1'b1;
      if (fill != CW'(WINDOW)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Sample capture, squares and running sums.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= sample_mv;
      first_r  <= (fill == '0);
    end
    if (cmd.sq_new) begin
      sq_new_r <= mul_out;
      old_r    <= old_val;
    end
    if (cmd.sq_old) begin
      sq_old_r <= mul_out;
    end
    if (cmd.update) begin
      if (first_r) begin
        first_val <= sample_r;
        sum       <= SUM_W'(WINDOW) * SUM_W'(sample_r);
        sumsq     <= Q_W'(WINDOW) * Q_W'(sq_new_r);
      end else begin
        sum   <= sum + SUM_W'(sample_r) - SUM_W'(old_r);
        sumsq <= sumsq + Q_W'(sq_new_r) - Q_W'(sq_old_r);
      end
    end
  end

  // N*Q minus S*S by shift and subtract, one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      acc    <= D_W'(WINDOW) * D_W'(sumsq);
      mcand  <= D_W'(sum);
      mplier <= sum;
      den    <= SUM_W'(WINDOW) * SUM_W'(fs_eff);
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        acc <= acc - mcand;
      end
      mcand  <= {mcand[D_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[SUM_W-1:1]};
    end
  end

  // Integer square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      dsh    <= acc;
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      dsh <= {dsh[D_W-3:0], 2'b00};
      if (sq_shift >= sq_trial) begin
        sq_rem <= RM_W'(sq_shift - sq_trial);
        root   <= {root[SUM_W-2:0], 1'b1};
      end else begin
        sq_rem <= RM_W'(sq_shift);
        root   <= {root[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Restoring division of root * 2^15 by N * full scale, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      clamp_r <= status.clamp;
      dv_rem  <= RM_W'(root);
      quot    <= '0;
    end else if (cmd.div_step) begin
      if (dv_shift >= RM_W'(den)) begin
        dv_rem <= dv_shift - RM_W'(den);
        quot   <= {quot[QBITS-2:0], 1'b1};
      end else begin
        dv_rem <= dv_shift;
        quot   <= {quot[QBITS-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      indicator_q15 <= clamp_r ? ONE_Q15 : IND_W'(quot);
    end
  end

endmodule

// ===== src/wsm_controller.sv =====
// Controller: sequences one transaction through the datapath and drives the handshakes.
module wsm_controller #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  wsm_pkg::wsm_status_t status,
  output wsm_pkg::wsm_cmd_t    cmd
);

  import wsm_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  wsm_state_t       state;
  wsm_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign in_stall = (state != ST_IDLE);

  // State, step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_SQNEW;
        end
      end
      ST_SQNEW: begin
        cmd.sq_new = 1'b1;
        state_next = ST_SQOLD;
      end
      ST_SQOLD: begin
        cmd.sq_old = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_MULINIT;
      end
      ST_MULINIT: begin
        cmd.mul_init = 1'b1;
        cnt_next     = CNT_W'(SUM_W);
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = ST_SQRTINIT;
        end
      end
      ST_SQRTINIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = CNT_W'(SUM_W);
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = ST_DIVCHK;
        end
      end
      ST_DIVCHK: begin
        cmd.div_init = 1'b1;
        cnt_next     = CNT_W'(QBITS);
        state_next   = status.clamp ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the output register once the previous result has left.
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/window_stddev_monitor.sv =====
// Top level of the sliding-window standard deviation monitor.
//
//   Channel   Signals                               Direction
//   input     in_valid, in_stall, sample_mv         sample in
//   output    out_valid, out_stall, indicator_q15   indicator out
//   config    cfg_wr_en, cfg_wr_data                full-scale deviation write
//
// A transaction steps from acceptance through squaring, update, the bit-serial multiply
// of the window sum, the bit-serial square root and the divide to the output register;
// the divide is skipped on saturation. The multiply and the square root dominate its length.
// A new sample is taken while the previous result still waits in the output register.
// Reset (synchronous) clears the window state; no clearing pass is needed.
// A stalled result holds the controller in its last state until the output register frees.
module window_stddev_monitor #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wsm_pkg::SAMPLE_W-1:0] sample_mv,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wsm_pkg::IND_W-1:0]    indicator_q15,
  input  logic                         cfg_wr_en,
  input  logic [wsm_pkg::FS_W-1:0]     cfg_wr_data
);

  import wsm_pkg::*;

  wsm_cmd_t    cmd;
  wsm_status_t status;

  wsm_controller #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wsm_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .sample_mv     (sample_mv),
    .indicator_q15 (indicator_q15)
  );

  // The controller issues at most one command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command active");

  // An accepted sample blocks the input channel in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after acceptance");

  // A result never exceeds 1.0 in Q1.15.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (indicator_q15 <= ONE_Q15))
    else $error("indicator above full scale");

  // A new result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

endmodule
